// ===== design/icv_pkg.sv =====
package icv_pkg;

   localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_XOROUT   = 32'hFFFF_FFFF;
   localparam logic [31:0] STAMP_NONE   = 32'h0000_0000;
   localparam logic [31:0] STAMP_ERASED = 32'hFFFF_FFFF;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_UNSTAMPED  = 3'd1,
      ST_ERASED     = 3'd2,
      ST_MISMATCH   = 3'd3,
      ST_BAD_REGION = 3'd4
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] computed_crc;
      logic [31:0] region_length;
      logic        trusted;
   } result_type;

   function automatic logic [31:0] nib_entry(input logic [3:0] idx);
      logic [31:0] val;
      case (idx)
         4'h0:    val = 32'h0000_0000;
         4'h1:    val = 32'h1DB7_1064;
         4'h2:    val = 32'h3B6E_20C8;
         4'h3:    val = 32'h26D9_30AC;
         4'h4:    val = 32'h76DC_4190;
         4'h5:    val = 32'h6B6B_51F4;
         4'h6:    val = 32'h4DB2_6158;
         4'h7:    val = 32'h5005_713C;
         4'h8:    val = 32'hEDB8_8320;
         4'h9:    val = 32'hF00F_9344;
         4'hA:    val = 32'hD6D6_A3E8;
         4'hB:    val = 32'hCB61_B38C;
         4'hC:    val = 32'h9B64_C2B0;
         4'hD:    val = 32'h86D3_D2D4;
         4'hE:    val = 32'hA00A_E278;
         4'hF:    val = 32'hBDBD_F21C;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

// ===== design/icv_absorb.sv =====
module icv_absorb (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);

   logic [31:0] mix;
   logic [31:0] step_one;

   always_comb begin
      mix      = crc_cur ^ {24'h0, data_byte};
      step_one = {4'h0, mix[31:4]} ^ icv_pkg::nib_entry(mix[3:0]);
      crc_next = {4'h0, step_one[31:4]} ^ icv_pkg::nib_entry(step_one[3:0]);
   end

endmodule

// ===== design/icv_verdict.sv =====
module icv_verdict (
   input  logic                  region_empty,
   input  logic [31:0]           crc_acc,
   input  logic [31:0]           byte_count,
   input  logic [31:0]           expected_crc,
   output icv_pkg::result_type   result
);

   logic [31:0]         crc_final;
   icv_pkg::status_type status;

   always_comb begin
      crc_final = crc_acc ^ icv_pkg::CRC_XOROUT;
      if (expected_crc == icv_pkg::STAMP_NONE) begin
         status = icv_pkg::ST_UNSTAMPED;
      end else if (expected_crc == icv_pkg::STAMP_ERASED) begin
         status = icv_pkg::ST_ERASED;
      end else if (crc_final == expected_crc) begin
         status = icv_pkg::ST_OK;
      end else begin
         status = icv_pkg::ST_MISMATCH;
      end

      if (region_empty) begin
         result.status        = icv_pkg::ST_BAD_REGION;
         result.computed_crc  = 32'h0;
         result.region_length = 32'h0;
         result.trusted       = 1'b0;
      end else begin
         result.status        = status;
         result.computed_crc  = crc_final;
         result.region_length = byte_count;
         result.trusted       = (status == icv_pkg::ST_OK) || (status == icv_pkg::ST_UNSTAMPED);
      end
   end

endmodule

// ===== design/image_crc32_verifier.sv =====
// a result transaction is formed when the byte that holds the last or empty flag moves
// from the input register into the output register
// throughput: one byte per cycle, set by the byte update on the crc register, while no
// stalled result holds back a byte that ends a region; results wait in an output register while bytes flow
// reset (synchronous, active high) clears the stamp to 0, the crc to all ones,
// the byte count to 0 and empties the input and output registers
module image_crc32_verifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        req_region_empty,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_computed_crc,
   output logic [31:0] rsp_region_length,
   output logic        rsp_trusted
);

   logic [31:0] expected_ff;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;
   logic        in_empty_ff;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] count_ff, count_in;
   logic        out_valid_ff, out_valid_in;
   icv_pkg::result_type out_ff;

   logic        produces;
   logic        advance;
   logic        req_take;
   logic [31:0] crc_step;
   logic [31:0] count_step;
   icv_pkg::result_type verdict;

   icv_absorb u_absorb (
      .crc_cur   (crc_ff),
      .data_byte (in_data_ff),
      .crc_next  (crc_step)
   );

   assign count_step = (count_ff == icv_pkg::COUNT_MAX) ? count_ff : count_ff + 32'd1;

   icv_verdict u_verdict (
      .region_empty (in_empty_ff),
      .crc_acc      (crc_step),
      .byte_count   (count_step),
      .expected_crc (expected_ff),
      .result       (verdict)
   );

   assign produces  = in_last_ff || in_empty_ff;
   assign advance   = in_valid_ff && (!produces || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      crc_in      = crc_ff;
      count_in    = count_ff;
      if (advance) begin
         if (produces) begin
            crc_in   = icv_pkg::CRC_INIT;
            count_in = 32'h0;
         end else begin
            crc_in   = crc_step;
            count_in = count_step;
         end
      end
      out_valid_in = (out_valid_ff && rsp_stall) || (advance && produces);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff  <= 32'h0;
         in_valid_ff  <= 1'b0;
         crc_ff       <= icv_pkg::CRC_INIT;
         count_ff     <= 32'h0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            expected_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff  <= req_data_byte;
         in_last_ff  <= req_last_byte;
         in_empty_ff <= req_region_empty;
      end
      if (advance && produces) begin
         out_ff <= verdict;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_computed_crc  = out_ff.computed_crc;
   assign rsp_region_length = out_ff.region_length;
   assign rsp_trusted       = out_ff.trusted;

   a_trusted_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_trusted == ((rsp_status == icv_pkg::ST_OK)
                                     || (rsp_status == icv_pkg::ST_UNSTAMPED))))
      else $error("trusted flag disagrees with status");

   a_bad_region_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == icv_pkg::ST_BAD_REGION)
         |-> (rsp_computed_crc == 32'h0 && rsp_region_length == 32'h0))
      else $error("bad region result carries nonzero crc or length");

   a_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != icv_pkg::ST_BAD_REGION) |-> (rsp_region_length != 32'h0))
      else $error("checked region reports zero length");

   a_restart_after_result: assert property (@(posedge clock) disable iff (reset)
      (advance && produces) |=> (crc_ff == icv_pkg::CRC_INIT && count_ff == 32'h0))
      else $error("running state not restarted after result");

   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> (crc_ff == icv_pkg::CRC_INIT && count_ff == 32'h0
                        && !in_valid_ff && !out_valid_ff))
      else $error("state not cleared by reset");

endmodule

// ===== dv/image_crc32_verifier_tb.sv =====
module image_crc32_verifier_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          WATCHDOG_MAX  = 2000;

   typedef logic [7:0] image_q [$];

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        req_region_empty;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_computed_crc;
   logic [31:0] rsp_region_length;
   logic        rsp_trusted;

   // predictor state
   logic [31:0] stamp_model;
   logic [31:0] run_crc;
   logic [31:0] run_count;
   icv_pkg::result_type expected_results [$];

   int  accepted_items = 0;
   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  send_idle_pct  = 0;
   int  recv_idle_pct  = 0;
   logic rx_hold = 1'b0;
   event hold_kick;

   image_crc32_verifier u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .req_region_empty  (req_region_empty),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_computed_crc  (rsp_computed_crc),
      .rsp_region_length (rsp_region_length),
      .rsp_trusted       (rsp_trusted)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // crc arithmetic
   function automatic logic [31:0] poly_nibble(input logic [3:0] nib);
      logic [31:0] v;
      v = {28'h0, nib};
      repeat (4) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      return v;
   endfunction

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      c = c ^ {24'h0, b};
      repeat (2) c = (c >> 4) ^ poly_nibble(c[3:0]);
      return c;
   endfunction

   function automatic logic [31:0] image_crc(input image_q img);
      logic [31:0] c;
      c = icv_pkg::CRC_INIT;
      foreach (img[i]) c = crc_byte(c, img[i]);
      return c ^ icv_pkg::CRC_XOROUT;
   endfunction

   // four bytes that drive the final crc of a fresh region to a chosen value
   function automatic image_q forge_image(input logic [31:0] final_crc);
      logic [31:0] reg_val;
      logic [31:0] word;
      logic [3:0]  idx;
      image_q      img;
      reg_val = final_crc ^ icv_pkg::CRC_XOROUT;
      for (int step = 0; step < 8; step++) begin
         idx = 4'h0;
         for (int i = 0; i < 16; i++) begin
            if (poly_nibble(4'(i)) >> 28 == reg_val >> 28) idx = 4'(i);
         end
         reg_val = ((reg_val ^ poly_nibble(idx)) << 4) | {28'h0, idx};
      end
      word = reg_val ^ icv_pkg::CRC_INIT;
      for (int k = 0; k < 4; k++) img.push_back(word[8*k +: 8]);
      return img;
   endfunction

   function automatic image_q random_image();
      int     len;
      image_q img;
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 6);
      repeat (len) img.push_back(8'($urandom_range(255)));
      return img;
   endfunction

   function automatic void restart_region();
      run_crc   = icv_pkg::CRC_INIT;
      run_count = '0;
   endfunction

   function automatic void predict_transaction(input logic [7:0] data, input logic last,
                                               input logic empty);
      icv_pkg::result_type r;
      logic [31:0] fin;
      accepted_items++;
      if (empty) begin
         r.status        = icv_pkg::ST_BAD_REGION;
         r.computed_crc  = '0;
         r.region_length = '0;
         r.trusted       = 1'b0;
         expected_results.push_back(r);
         restart_region();
         return;
      end
      run_crc = crc_byte(run_crc, data);
      if (run_count != icv_pkg::COUNT_MAX) run_count++;
      if (!last) return;
      fin = run_crc ^ icv_pkg::CRC_XOROUT;
      if (stamp_model == icv_pkg::STAMP_NONE) r.status = icv_pkg::ST_UNSTAMPED;
      else if (stamp_model == icv_pkg::STAMP_ERASED) r.status = icv_pkg::ST_ERASED;
      else if (fin == stamp_model) r.status = icv_pkg::ST_OK;
      else r.status = icv_pkg::ST_MISMATCH;
      r.computed_crc  = fin;
      r.region_length = run_count;
      r.trusted       = (r.status == icv_pkg::ST_OK) || (r.status == icv_pkg::ST_UNSTAMPED);
      expected_results.push_back(r);
      restart_region();
   endfunction

   // result checking and receiver stalls
   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %h actual %h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      icv_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transaction: status %0d crc %h length %h",
                           rsp_status, rsp_computed_crc, rsp_region_length);
            end else begin
               want = expected_results.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("computed_crc", want.computed_crc, rsp_computed_crc);
               compare_field("region_length", want.region_length, rsp_region_length);
               compare_field("trusted", 32'(want.trusted), 32'(rsp_trusted));
            end
         end
         rsp_stall <= rx_hold || ($urandom_range(99) < recv_idle_pct);
      end
   end

   always begin
      @(hold_kick);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_MAX);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // stimulus helpers
   task automatic drive_item(input logic [7:0] data, input logic last, input logic empty);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_last_byte    <= last;
      req_region_empty <= empty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_transaction(data, last, empty);
   endtask

   task automatic send_image(input image_q img);
      foreach (img[i]) drive_item(img[i], i == img.size() - 1, 1'b0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_stamp(input logic [31:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      stamp_model = value;
   endtask

   // tests
   task automatic test_unstamped();
      write_stamp(icv_pkg::STAMP_NONE);
      drive_item(8'h00, 1'b1, 1'b0);
      drive_item(8'hFF, 1'b1, 1'b0);
      drive_item(8'hA5, 1'b1, 1'b0);
      drive_item(8'h5A, 1'b1, 1'b0);
      // empty region with and without the last flag
      drive_item(8'hFF, 1'b0, 1'b1);
      drive_item(8'h00, 1'b1, 1'b1);
      // broken region drops the bytes taken so far
      drive_item(8'h12, 1'b0, 1'b0);
      drive_item(8'h34, 1'b0, 1'b0);
      drive_item(8'hC3, 1'b0, 1'b1);
      // crc of zero still reads as unstamped
      send_image(forge_image(32'h0000_0000));
   endtask

   task automatic test_erased();
      write_stamp(icv_pkg::STAMP_ERASED);
      send_image(forge_image(32'hFFFF_FFFF));
      drive_item(8'h7E, 1'b1, 1'b0);
   endtask

   task automatic test_stamp_compare();
      write_stamp(32'h0000_0001);
      send_image(forge_image(32'h0000_0001));
      write_stamp(32'hFFFF_FFFE);
      send_image(forge_image(32'hFFFF_FFFE));
      drive_item(8'h3C, 1'b1, 1'b0);
   endtask

   task automatic test_output_hold();
      settle();
      -> hold_kick;
      repeat (48) drive_item(8'($urandom_range(255)), 1'b1, 1'b0);
      // sender waits for the backlog to drain
      settle();
   endtask

   task automatic test_random_images(input int count);
      int     target;
      int     mode;
      int     pick;
      int     cut;
      image_q golden;
      image_q img;
      target = accepted_items + count;
      while (accepted_items < target) begin
         mode   = $urandom_range(3);
         golden = random_image();
         case (mode)
            0: write_stamp(icv_pkg::STAMP_NONE);
            1: write_stamp(icv_pkg::STAMP_ERASED);
            2: write_stamp($urandom());
            default: write_stamp(image_crc(golden));
         endcase
         repeat ($urandom_range(4, 10)) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               drive_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            end else if (mode == 3 && pick < 50) begin
               send_image(golden);
            end else begin
               img = random_image();
               if (pick < 15) begin
                  cut = $urandom_range(img.size() - 1);
                  for (int i = 0; i < cut; i++) drive_item(img[i], 1'b0, 1'b0);
                  drive_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
               end else begin
                  send_image(img);
               end
            end
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_last_byte    = 1'b0;
      req_region_empty = 1'b0;
      stamp_model      = icv_pkg::STAMP_NONE;
      restart_region();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      recv_idle_pct = 54;
      test_unstamped();
      test_erased();
      test_stamp_compare();
      test_random_images(210);
      test_output_hold();

      send_idle_pct = 54;
      recv_idle_pct = 15;
      test_random_images(210);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_images(210);

      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
